### rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque block.
`timescale 1ns / 1ps

package bdq_pkg;

	// Command codes carried in the low bits of the input word.
	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FIRST  = 3'd2,
		CMD_POP_LAST   = 3'd3,
		CMD_SEARCH     = 3'd4,
		CMD_REMOVE     = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	// What a slot cell loads at the next edge.
	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_FROM_LEFT  = 2'd2,
		CELL_FROM_RIGHT = 2'd3
	} cell_op_t;

	localparam int unsigned CMD_W      = 3;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned S_FIELDS_W = CMD_W + DATA_W;
	localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

endpackage

### rtl/bdq_cell.sv
// One slot cell of the deque chain: holds a word, shifts to/from neighbors.
`timescale 1ns / 1ps

module bdq_cell #(
	parameter int unsigned ITEM_WIDTH = 32
) (
	input  logic                  clk,
	input  bdq_pkg::cell_op_t     op,
	input  logic [ITEM_WIDTH-1:0] load_word,
	input  logic [ITEM_WIDTH-1:0] left_word,
	input  logic [ITEM_WIDTH-1:0] right_word,
	input  logic [ITEM_WIDTH-1:0] key,
	output logic [ITEM_WIDTH-1:0] word,
	output logic                  hit
);
	import bdq_pkg::*;

	logic [ITEM_WIDTH-1:0] slot_q;

	// no reset: contents only read below the fill count
	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:       slot_q <= slot_q;
			CELL_LOAD:       slot_q <= load_word;
			CELL_FROM_LEFT:  slot_q <= left_word;
			CELL_FROM_RIGHT: slot_q <= right_word;
			default:         slot_q <= slot_q;
		endcase
	end

	assign word = slot_q;
	assign hit  = (slot_q == key);

endmodule

### rtl/bounded_deque_with_search_remove.sv
// Top level of the bounded deque: cell chain, command control and result buffer.
// Push, pop, search and clear: result passes the result stage and output register; one per
//   cycle while the output buffer has room. Remove all equal: rotates the N held words once
//   through the cell chain, one word per cycle, and no new command is taken until it ends
//   (N = count held when the remove starts).
// Reset (arst_n low, asynchronous): queue empty, output buffer empty; slot contents
//   stay undefined until written.
`timescale 1ns / 1ps

module bounded_deque_with_search_remove #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned ITEM_WIDTH = 32,
	localparam int unsigned CW        = $clog2(DEPTH + 1),
	localparam int unsigned M_FIELDS_W = 99 + 2 * CW,
	localparam int unsigned M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// lowest bit up: cmd[3], item_value[32], zero pad
	input  logic [bdq_pkg::S_TDATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// lowest bit up: ok, popped_value[32], removed_count[CW], entry_total[CW],
	// is_empty, is_full, first_value[32], last_value[32], zero pad
	output logic [M_TDATA_W-1:0]               m_tdata
);
	import bdq_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// ---------------------------------------------------------------
	// Input word unpacking
	// ---------------------------------------------------------------
	cmd_t                  cmd;
	logic [DATA_W-1:0]     item_raw;
	logic [ITEM_WIDTH-1:0] item_key;
	logic                  accept;

	assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
	assign item_raw = s_tdata[S_FIELDS_W-1:CMD_W];
	assign item_key = ITEM_WIDTH'(item_raw);   // masked to the item width
	assign accept   = s_tvalid & s_tready;

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	logic [CW-1:0]         occ_q;        // words held
	logic                  busy_q;       // remove rotation in progress
	logic [CW-1:0]         rem_q;        // words still to visit in the rotation
	logic [CW-1:0]         removed_q;    // matches dropped so far
	logic [ITEM_WIDTH-1:0] key_q;        // remove key

	// result stage: command done, state now holds the post-command view
	logic                  done_s1;
	logic                  ok_s1;
	logic [ITEM_WIDTH-1:0] popped_s1;
	logic [CW-1:0]         removed_s1;

	logic is_empty_now, is_full_now;
	assign is_empty_now = (occ_q == '0);
	assign is_full_now  = (occ_q >= CW'(DEPTH));

	// ---------------------------------------------------------------
	// Cell chain. Cell 0 is the front.
	// ---------------------------------------------------------------
	cell_op_t              cell_op   [DEPTH];
	logic [ITEM_WIDTH-1:0] cell_word [DEPTH];
	logic                  cell_hit  [DEPTH];
	logic [ITEM_WIDTH-1:0] load_word;
	logic [ITEM_WIDTH-1:0] cell_key;

	// during remove the front word circulates back to the tail
	assign load_word = busy_q ? cell_word[0] : item_key;
	assign cell_key  = busy_q ? key_q : item_key;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [ITEM_WIDTH-1:0] left_w, right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[g+1];
		end

		bdq_cell #(
			.ITEM_WIDTH(ITEM_WIDTH)
		) u_cell (
			.clk       (clk),
			.op        (cell_op[g]),
			.load_word (load_word),
			.left_word (left_w),
			.right_word(right_w),
			.key       (cell_key),
			.word      (cell_word[g]),
			.hit       (cell_hit[g])
		);
	end

	// tail word (index occ-1), used by pop last and the status fields
	logic [CW-1:0]         tail_pos;
	logic [IW-1:0]         tail_idx;
	logic [ITEM_WIDTH-1:0] tail_word;
	assign tail_pos  = occ_q - CW'(1);
	assign tail_idx  = tail_pos[IW-1:0];
	assign tail_word = cell_word[tail_idx];

	// search: any held cell equal to the key
	logic search_hit;
	always_comb begin
		search_hit = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_hit[i] && (CW'(i) < occ_q))
				search_hit = 1'b1;
		end
	end

	// front match during a rotation step
	logic front_hit;
	assign front_hit = cell_hit[0];

	// per-cell operation decode
	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			cell_op[i] = CELL_HOLD;
		if (busy_q) begin
			// shift everything toward the front; a kept front word lands at the tail
			for (int i = 0; i < DEPTH; i++) begin
				if (!front_hit && (CW'(i) == tail_pos))
					cell_op[i] = CELL_LOAD;
				else
					cell_op[i] = CELL_FROM_RIGHT;
			end
		end else if (accept) begin
			unique case (cmd)
				CMD_PUSH_BACK: begin
					if (!is_full_now) begin
						for (int i = 0; i < DEPTH; i++)
							if (CW'(i) == occ_q)
								cell_op[i] = CELL_LOAD;
					end
				end
				CMD_PUSH_FRONT: begin
					if (!is_full_now) begin
						for (int i = 0; i < DEPTH; i++)
							cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
					end
				end
				CMD_POP_FIRST: begin
					if (!is_empty_now) begin
						for (int i = 0; i < DEPTH; i++)
							cell_op[i] = CELL_FROM_RIGHT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Command sequencing
	// ---------------------------------------------------------------
	logic [CW-1:0] removed_nxt;
	assign removed_nxt = removed_q + CW'(front_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			busy_q    <= 1'b0;
			rem_q     <= '0;
			removed_q <= '0;
			done_s1   <= 1'b0;
		end else begin
			done_s1 <= 1'b0;
			if (busy_q) begin
				if (front_hit) begin
					occ_q     <= occ_q - CW'(1);
					removed_q <= removed_nxt;
				end
				rem_q <= rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					busy_q  <= 1'b0;
					done_s1 <= 1'b1;
				end
			end else if (accept) begin
				unique case (cmd)
					CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
						if (!is_full_now)
							occ_q <= occ_q + CW'(1);
						done_s1 <= 1'b1;
					end
					CMD_POP_FIRST, CMD_POP_LAST: begin
						if (!is_empty_now)
							occ_q <= occ_q - CW'(1);
						done_s1 <= 1'b1;
					end
					CMD_REMOVE: begin
						removed_q <= '0;
						rem_q     <= occ_q;
						if (is_empty_now)
							done_s1 <= 1'b1;
						else
							busy_q <= 1'b1;
					end
					CMD_CLEAR: begin
						occ_q   <= '0;
						done_s1 <= 1'b1;
					end
					default: done_s1 <= 1'b1;   // search and unused code
				endcase
			end
		end
	end

	// result payload of the command just executed
	always_ff @(posedge clk) begin
		if (busy_q) begin
			ok_s1      <= (removed_nxt != '0);
			popped_s1  <= '0;
			removed_s1 <= removed_nxt;
		end else if (accept) begin
			key_q      <= item_key;
			ok_s1      <= 1'b0;
			popped_s1  <= '0;
			removed_s1 <= '0;
			unique case (cmd)
				CMD_PUSH_BACK, CMD_PUSH_FRONT: ok_s1 <= !is_full_now;
				CMD_POP_FIRST: begin
					ok_s1 <= !is_empty_now;
					if (!is_empty_now)
						popped_s1 <= cell_word[0];
				end
				CMD_POP_LAST: begin
					ok_s1 <= !is_empty_now;
					if (!is_empty_now)
						popped_s1 <= tail_word;
				end
				CMD_SEARCH: ok_s1 <= search_hit;
				CMD_CLEAR:  ok_s1 <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Result word assembly: status read from the live post-command state
	// ---------------------------------------------------------------
	logic [DATA_W-1:0]    popped_o, first_o, last_o;
	logic [63:0]          popped_ext, first_ext, last_ext;
	logic [M_TDATA_W-1:0] res_word;

	assign popped_ext = 64'(popped_s1);
	assign first_ext  = is_empty_now ? 64'd0 : 64'(cell_word[0]);
	assign last_ext   = is_empty_now ? 64'd0 : 64'(tail_word);
	assign popped_o   = popped_ext[DATA_W-1:0];
	assign first_o    = first_ext[DATA_W-1:0];
	assign last_o     = last_ext[DATA_W-1:0];

	assign res_word = M_TDATA_W'({last_o, first_o, is_full_now, is_empty_now,
	                              occ_q, removed_s1, popped_o, ok_s1});

	// ---------------------------------------------------------------
	// Output register plus skid register
	// ---------------------------------------------------------------
	logic [M_TDATA_W-1:0] out_q, sk_q;
	logic                 out_v_q, sk_v_q;
	logic                 take;

	assign take     = out_v_q & m_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// a new command's result reaches the result stage in the next cycle; make sure a slot is free then
	assign s_tready = !busy_q && !sk_v_q && !(done_s1 && out_v_q && !m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else begin
			if (take) begin
				if (!sk_v_q)
					out_v_q <= 1'b0;
				sk_v_q <= 1'b0;
			end
			if (done_s1) begin
				if (!out_v_q || take)
					out_v_q <= 1'b1;
				else
					sk_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && sk_v_q)
			out_q <= sk_q;
		if (done_s1) begin
			if (!out_v_q || take)
				out_q <= res_word;
			else
				sk_q <= res_word;
		end
	end

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid holds a word while output register is empty");

	a_rot_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0) && (rem_q <= occ_q))
		else $error("rotation counter out of step with occupancy");

	a_done_next: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd != CMD_REMOVE) |=> done_s1)
		else $error("command result missing");

endmodule

### verif/bdq_result_checker.sv
// Result checker for the bounded deque: tracks held words, predicts and compares results.
`timescale 1ns / 1ps

module bdq_result_checker #(
	parameter int unsigned DEPTH     = 16,
	localparam int unsigned CW        = $clog2(DEPTH + 1),
	localparam int unsigned M_TDATA_W = ((99 + 2 * CW + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// lowest bit up: cmd[3], item_value[32], zero pad
	input  logic [bdq_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// lowest bit up: ok, popped_value[32], removed_count[CW], entry_total[CW],
	// is_empty, is_full, first_value[32], last_value[32], zero pad
	input  logic [M_TDATA_W-1:0]          m_tdata,
	output int                            fail_count,
	output int                            pending
);
	import bdq_pkg::*;

	typedef struct {
		logic          ok;
		logic [31:0]   popped;
		logic [CW-1:0] removed;
		logic [CW-1:0] total;
		logic          empty;
		logic          full;
		logic [31:0]   first;
		logic [31:0]   last;
	} deque_status_t;

	logic [31:0]   held_words[$];
	deque_status_t status_queue[$];
	deque_status_t want;
	deque_status_t got;
	int            mismatches = 0;
	int            waiting = 0;

	assign fail_count = mismatches;
	assign pending    = waiting;

	// Apply one command to the tracked deque and return the status it produces.
	function automatic deque_status_t apply_command(input logic [2:0] op, input logic [31:0] word);
		deque_status_t r;
		logic [31:0]   kept_words[$];
		r = '{default: '0};
		case (op)
			CMD_PUSH_BACK: begin
				if (held_words.size() < DEPTH) begin
					held_words.push_back(word);
					r.ok = 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (held_words.size() < DEPTH) begin
					held_words.push_front(word);
					r.ok = 1'b1;
				end
			end
			CMD_POP_FIRST: begin
				if (held_words.size() > 0) begin
					r.popped = held_words.pop_front();
					r.ok     = 1'b1;
				end
			end
			CMD_POP_LAST: begin
				if (held_words.size() > 0) begin
					r.popped = held_words.pop_back();
					r.ok     = 1'b1;
				end
			end
			CMD_SEARCH: begin
				foreach (held_words[i])
					if (held_words[i] == word)
						r.ok = 1'b1;
			end
			CMD_REMOVE: begin
				foreach (held_words[i]) begin
					if (held_words[i] == word)
						r.removed++;
					else
						kept_words.push_back(held_words[i]);
				end
				held_words = kept_words;
				r.ok       = (r.removed != 0);
			end
			CMD_CLEAR: begin
				held_words.delete();
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.total = CW'(held_words.size());
		r.empty = (held_words.size() == 0);
		r.full  = (held_words.size() >= DEPTH);
		r.first = (held_words.size() != 0) ? held_words[0] : 32'd0;
		r.last  = (held_words.size() != 0) ? held_words[$] : 32'd0;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (status_queue.size() == 0) begin
					$display("%0t: unexpected result word: expected none, actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want        = status_queue.pop_front();
					got.ok      = m_tdata[0];
					got.popped  = m_tdata[32:1];
					got.removed = m_tdata[33 +: CW];
					got.total   = m_tdata[33 + CW +: CW];
					got.empty   = m_tdata[33 + 2 * CW];
					got.full    = m_tdata[34 + 2 * CW];
					got.first   = m_tdata[35 + 2 * CW +: 32];
					got.last    = m_tdata[67 + 2 * CW +: 32];
					check_field("ok", 32'(want.ok), 32'(got.ok));
					check_field("popped_value", want.popped, got.popped);
					check_field("removed_count", 32'(want.removed), 32'(got.removed));
					check_field("entry_total", 32'(want.total), 32'(got.total));
					check_field("is_empty", 32'(want.empty), 32'(got.empty));
					check_field("is_full", 32'(want.full), 32'(got.full));
					check_field("first_value", want.first, got.first);
					check_field("last_value", want.last, got.last);
				end
			end
			if (s_tvalid && s_tready)
				status_queue.push_back(apply_command(s_tdata[2:0], s_tdata[34:3]));
			waiting = status_queue.size();
		end
	end

endmodule

### verif/tb.sv
// Testbench top for the bounded deque: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import bdq_pkg::*;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned CW          = $clog2(DEPTH + 1);
	localparam int unsigned M_TDATA_W   = ((99 + 2 * CW + 7) / 8) * 8;
	// Cycle cap with a wide margin over the slowest legal run (gap, stall, full remove).
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned PHASES      = 6;
	localparam int unsigned PHASE_WORDS = 150;
	// Push share per phase: high and low shares mix filling and draining so full and empty both recur.
	localparam int unsigned PUSH_BIAS [PHASES] = '{70, 30, 55, 80, 50, 20};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	int                   fail_count;
	int                   pending;
	int unsigned          cycle_count = 0;
	// When set, neither side idles: back-to-back words on both channels.
	logic                 no_idle = 1'b0;

	bounded_deque_with_search_remove #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bdq_result_checker #(.DEPTH(DEPTH)) result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_deque_with_search_remove verification failed");
			$finish;
		end
	end

	// Send one command word. Valid stays high from one word to the next when the
	// drawn gap is zero, so it is only ever assigned once per edge.
	task automatic send_word(input cmd_t op, input logic [31:0] word);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - 35){1'b0}}, word, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold the sender off until every predicted result word has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Mostly a small pool of words so search and remove hit often and duplicates pile
	// up; the rest is full-range random to toggle every data bit.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_00A5;
			3: return 32'h8000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t pick_command(input int unsigned push_pct);
		int unsigned roll;
		int unsigned sel;
		roll = $urandom_range(0, 99);
		sel  = $urandom_range(0, 99);
		if (roll < push_pct)
			return sel[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
		if (sel < 40)
			return CMD_POP_FIRST;
		if (sel < 70)
			return CMD_POP_LAST;
		if (sel < 85)
			return CMD_SEARCH;
		if (sel < 97)
			return CMD_REMOVE;
		return CMD_CLEAR;
	endfunction

	// Receiver: random stall before each result word, none while no_idle is set.
	initial begin
		int unsigned stall;
		m_tready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int unsigned k;
		int unsigned phase;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue: pops, search and remove all miss; clear is still legal.
		send_word(CMD_POP_FIRST, 32'h1234_5678);
		send_word(CMD_POP_LAST, 32'h1234_5678);
		send_word(CMD_SEARCH, 32'h0000_0000);
		send_word(CMD_REMOVE, 32'h0000_0000);
		send_word(CMD_CLEAR, 32'hFFFF_FFFF);

		// Extreme words at both ends, then a hit and a miss.
		send_word(CMD_PUSH_BACK, 32'h0000_0000);
		send_word(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send_word(CMD_SEARCH, 32'h0000_0000);
		send_word(CMD_SEARCH, 32'h0000_0001);

		// Fill to capacity with two interleaved patterns, then push onto a full queue.
		for (k = 0; k < DEPTH - 2; k++)
			send_word(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
				k[1] ? 32'hA5A5_A5A5 : 32'h5A5A_5A5A);
		send_word(CMD_PUSH_BACK, 32'h1111_1111);
		send_word(CMD_PUSH_FRONT, 32'h2222_2222);

		// Remove scattered duplicates from a full queue, pop both ends, clear.
		send_word(CMD_REMOVE, 32'hA5A5_A5A5);
		send_word(CMD_POP_FIRST, 32'h0);
		send_word(CMD_POP_LAST, 32'h0);
		send_word(CMD_CLEAR, 32'h0);
		drain_results();

		// Random phases; one runs without idling, and the sender pauses after each
		// until every result word is back.
		for (phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase == 3);
			for (k = 0; k < PHASE_WORDS; k++)
				send_word(pick_command(PUSH_BIAS[phase]), pick_word());
			drain_results();
		end
		no_idle = 1'b0;

		// Quiet tail catches any stray result word after a full-length remove.
		repeat (4 * DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("bounded_deque_with_search_remove verification clean");
		else
			$display("bounded_deque_with_search_remove verification failed");
		$finish;
	end

endmodule
